/* rtl/hba_pkg.sv */
package hba_pkg;

    localparam int OFF_W   = 16;
    localparam int SIZE_W  = 17;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 32;
    localparam int CIDX_W  = 6;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_ALLOC_FAIL   = 2'd1,
        ST_FREE_REJECT  = 2'd2
    } status_t;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC_Q,
        S_CALC_N,
        S_SCAN,
        S_APPLY,
        S_MERGE_LO,
        S_MERGE_HI,
        S_RESP
    } hba_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ALLOC,
        CELL_FREE,
        CELL_MERGE
    } cell_op_t;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } cell_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CIDX_W-1:0] idx;
        logic              split;
        logic [SIZE_W-1:0] need;
    } cmd_t;

    typedef struct packed {
        logic        func;
        logic [15:0] request_size;
        logic [15:0] payload_addr;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [15:0]       result_addr;
        logic [SIZE_W-1:0] used_bytes;
        logic [SIZE_W-1:0] free_bytes;
        logic [CNT_W-1:0]  block_count;
        logic [STAT_W-1:0] alloc_count;
        logic [STAT_W-1:0] free_count;
        logic [STAT_W-1:0] merge_count;
    } rsp_t;

endpackage

/* rtl/hba_stream_if.sv */
interface hba_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/hba_cell.sv */
module hba_cell
    import hba_pkg::*;
#(
    parameter int MY_IDX       = 0,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  cell_t prev,
    input  cell_t next,
    output cell_t q
);

    cell_t cell_reg;
    cell_t cell_next;
    int    k;

    always_comb
    begin
        k         = int'(cmd.idx);
        cell_next = cell_reg;
        case (cmd.op)
            CELL_ALLOC:
            begin
                if (MY_IDX == k)
                begin
                    cell_next.is_free = 1'b0;
                    if (cmd.split)
                        cell_next.size = cmd.need;
                end
                else if (cmd.split && MY_IDX == k + 1)
                begin
                    // new free remainder behind the chosen block
                    cell_next.offset  = prev.offset + OFF_W'(HEADER_BYTES)
                                        + cmd.need[OFF_W-1:0];
                    cell_next.size    = prev.size - cmd.need - SIZE_W'(HEADER_BYTES);
                    cell_next.is_free = 1'b1;
                end
                else if (cmd.split && MY_IDX > k + 1)
                    cell_next = prev;
            end
            CELL_FREE:
            begin
                if (MY_IDX == k)
                    cell_next.is_free = 1'b1;
            end
            CELL_MERGE:
            begin
                if (MY_IDX == k)
                    cell_next.size = cell_reg.size + SIZE_W'(HEADER_BYTES) + next.size;
                else if (MY_IDX > k)
                    cell_next = next;
            end
            default:
            begin
                cell_next = cell_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.offset  <= '0;
            cell_reg.size    <= (MY_IDX == 0) ? SIZE_W'(HEAP_BYTES - HEADER_BYTES) : '0;
            cell_reg.is_free <= (MY_IDX == 0);
        end
        else
            cell_reg <= cell_next;
    end

    assign q = cell_reg;

endmodule

/* rtl/heap_block_allocator.sv */
// Heap block allocator: keeps an address-ordered table of up to MAX_BLOCKS
// heap blocks in a row of cells, each cell holding one block (offset, payload
// size, free flag). A request on req is either an allocate (func 0) or a free
// (func 1); exactly one response comes back on rsp per request, carrying the
// status, the new payload offset and the running statistics after the
// request took effect. An allocate first rounds its size up to ALIGN_BYTES
// (a quotient, then a multiply back), then walks the table one cell per
// cycle (first fit stops at the first hit, best and worst fit walk all
// block_count cells), then claims and splits the chosen block; a free walks
// until it finds the named block, then releases it and merges it with its
// neighbors. Split and merge move the table by one cell, each cell taking its
// neighbor's contents. The user must write fit_mode on cfg only while idle;
// the block itself does not enforce it. Request cost grows with block_count.
module heap_block_allocator
    import hba_pkg::*;
#(
    parameter int HEAP_BYTES      = 65536,
    parameter int MAX_BLOCKS      = 64,
    parameter int HEADER_BYTES    = 16,
    parameter int MIN_ALLOC_BYTES = 16,
    parameter int ALIGN_BYTES     = 8
) (
    input logic clk,
    input logic rst_n,
    hba_stream_if.sink   req,
    hba_stream_if.sink   cfg,
    hba_stream_if.source rsp
);

    localparam int IW  = $clog2(MAX_BLOCKS);
    // size rounding: multiply by a reciprocal, exact for 17-bit operands
    localparam int RS  = SIZE_W + $clog2(ALIGN_BYTES);
    localparam longint unsigned RM = ((64'd1 << RS) + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int PW  = SIZE_W + RS + 1;

    hba_state_t state_reg, state_next;

    logic              func_reg,      func_next;
    logic [15:0]       size_reg,      size_next;
    logic [15:0]       addr_reg,      addr_next;
    logic [SIZE_W-1:0] quot_reg,      quot_next;
    logic [SIZE_W-1:0] need_reg,      need_next;
    logic [IW-1:0]     scan_reg,      scan_next;
    logic [IW-1:0]     pick_reg,      pick_next;
    logic              pick_ok_reg,   pick_ok_next;
    logic [SIZE_W-1:0] pick_size_reg, pick_size_next;
    logic [OFF_W-1:0]  pick_off_reg,  pick_off_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [SIZE_W-1:0] used_reg,      used_next;
    logic [STAT_W-1:0] allocs_reg,    allocs_next;
    logic [STAT_W-1:0] frees_reg,     frees_next;
    logic [STAT_W-1:0] merges_reg,    merges_next;
    status_t           status_reg,    status_next;
    logic [15:0]       result_reg,    result_next;
    logic [1:0]        mode_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    cell_t cell_q [MAX_BLOCKS];
    cmd_t  cmd;

    cell_t             cur, lo, hi;
    logic              fit, better, take, stop, last;
    logic              lo_merge, hi_merge, split, rsp_free;
    logic [SIZE_W:0]   split_lim;
    logic [PW-1:0]     prod;
    logic [SIZE_W-1:0] t_rnd;

    // ---------------- cell chain ----------------
    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_cell
        cell_t prev_c, next_c;
        if (g == 0)
        begin : g_first
            assign prev_c = '0;
        end
        else
        begin : g_prev
            assign prev_c = cell_q[g-1];
        end
        if (g == MAX_BLOCKS - 1)
        begin : g_last
            assign next_c = '0;
        end
        else
        begin : g_next
            assign next_c = cell_q[g+1];
        end
        hba_cell #(
            .MY_IDX       (g),
            .HEAP_BYTES   (HEAP_BYTES),
            .HEADER_BYTES (HEADER_BYTES)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .prev  (prev_c),
            .next  (next_c),
            .q     (cell_q[g])
        );
    end

    // ---------------- shared conditions ----------------
    always_comb
    begin
        cur      = cell_q[scan_reg];
        lo       = cell_q[IW'(pick_reg - 1'b1)];
        hi       = cell_q[IW'(pick_reg + 1'b1)];
        fit      = cur.is_free && (cur.size >= need_reg);
        better   = !pick_ok_reg
                   || (mode_reg == FIT_BEST  && cur.size < pick_size_reg)
                   || (mode_reg == FIT_WORST && cur.size > pick_size_reg);
        if (func_reg == FUNC_ALLOC)
        begin
            take = fit && better;
            stop = fit && mode_reg != FIT_BEST && mode_reg != FIT_WORST;
        end
        else
        begin
            take = !cur.is_free
                   && ({1'b0, cur.offset} + (OFF_W+1)'(HEADER_BYTES) == {1'b0, addr_reg});
            stop = take;
        end
        last      = CNT_W'(scan_reg) == count_reg - 1'b1;
        split_lim = {1'b0, need_reg} + (SIZE_W+1)'(HEADER_BYTES + MIN_ALLOC_BYTES);
        split     = ({1'b0, pick_size_reg} > split_lim)
                    && (count_reg < CNT_W'(MAX_BLOCKS));
        lo_merge  = (pick_reg != '0) && lo.is_free;
        hi_merge  = (CNT_W'(pick_reg) + 1'b1 < count_reg) && hi.is_free;
        t_rnd     = SIZE_W'(size_reg) + SIZE_W'(ALIGN_BYTES - 1);
        prod      = PW'(t_rnd) * PW'(RM);
        rsp_free  = !rsp_valid_reg || rsp.ready;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.func == FUNC_FREE)
                        state_next = S_SCAN;
                    else if (req.data.request_size == '0)
                        state_next = S_RESP;
                    else
                        state_next = S_CALC_Q;
                end
            end
            S_CALC_Q:   state_next = S_CALC_N;
            S_CALC_N:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (stop || (last && (pick_ok_reg || take)))
                    state_next = S_APPLY;
                else if (last)
                    state_next = S_RESP;
            end
            S_APPLY:    state_next = (func_reg == FUNC_FREE) ? S_MERGE_LO : S_RESP;
            S_MERGE_LO: state_next = S_MERGE_HI;
            S_MERGE_HI: state_next = S_RESP;
            S_RESP:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // ---------------- datapath and cell commands ----------------
    always_comb
    begin
        func_next      = func_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        quot_next      = quot_reg;
        need_next      = need_reg;
        scan_next      = scan_reg;
        pick_next      = pick_reg;
        pick_ok_next   = pick_ok_reg;
        pick_size_next = pick_size_reg;
        pick_off_next  = pick_off_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        allocs_next    = allocs_reg;
        frees_next     = frees_reg;
        merges_next    = merges_reg;
        status_next    = status_reg;
        result_next    = result_reg;
        cmd            = '{op: CELL_HOLD, idx: '0, split: 1'b0, need: need_reg};
        case (state_reg)
            S_IDLE:
            begin
                func_next    = req.data.func;
                size_next    = req.data.request_size;
                addr_next    = req.data.payload_addr;
                scan_next    = '0;
                pick_ok_next = 1'b0;
                result_next  = '0;
                status_next  = ST_ALLOC_FAIL;
            end
            S_CALC_Q:   quot_next = prod[RS +: SIZE_W];
            S_CALC_N:   need_next = SIZE_W'(quot_reg * SIZE_W'(ALIGN_BYTES));
            S_SCAN:
            begin
                if (take)
                begin
                    pick_next      = scan_reg;
                    pick_ok_next   = 1'b1;
                    pick_size_next = cur.size;
                    pick_off_next  = cur.offset;
                end
                scan_next = scan_reg + 1'b1;
                if (func_reg == FUNC_FREE)
                    status_next = ST_FREE_REJECT;
            end
            S_APPLY:
            begin
                status_next = ST_DONE;
                cmd.idx     = CIDX_W'(pick_reg);
                if (func_reg == FUNC_ALLOC)
                begin
                    cmd.op      = CELL_ALLOC;
                    cmd.split   = split;
                    count_next  = count_reg + CNT_W'(split);
                    used_next   = used_reg + (split ? need_reg : pick_size_reg)
                                  + SIZE_W'(HEADER_BYTES);
                    allocs_next = allocs_reg + 1'b1;
                    result_next = pick_off_reg + 16'(HEADER_BYTES);
                end
                else
                begin
                    cmd.op     = CELL_FREE;
                    used_next  = used_reg - pick_size_reg - SIZE_W'(HEADER_BYTES);
                    frees_next = frees_reg + 1'b1;
                end
            end
            S_MERGE_LO:
            begin
                // fold the freed block into a free block in front of it
                if (lo_merge)
                begin
                    cmd.op      = CELL_MERGE;
                    cmd.idx     = CIDX_W'(pick_reg - 1'b1);
                    pick_next   = pick_reg - 1'b1;
                    count_next  = count_reg - 1'b1;
                    merges_next = merges_reg + 1'b1;
                end
            end
            S_MERGE_HI:
            begin
                // absorb a free block right behind it
                if (hi_merge)
                begin
                    cmd.op      = CELL_MERGE;
                    cmd.idx     = CIDX_W'(pick_reg);
                    count_next  = count_reg - 1'b1;
                    merges_next = merges_reg + 1'b1;
                end
            end
            default:
            begin
                cmd.op = CELL_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= CNT_W'(1);
            used_reg    <= '0;
            allocs_reg  <= '0;
            frees_reg   <= '0;
            merges_reg  <= '0;
            mode_reg    <= '0;
            pick_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            used_reg    <= used_next;
            allocs_reg  <= allocs_next;
            frees_reg   <= frees_next;
            merges_reg  <= merges_next;
            pick_ok_reg <= pick_ok_next;
            if (cfg.valid)
                mode_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        quot_reg      <= quot_next;
        need_reg      <= need_next;
        scan_reg      <= scan_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        pick_off_reg  <= pick_off_next;
        status_reg    <= status_next;
        result_reg    <= result_next;
    end

    // ---------------- response register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (state_reg == S_RESP && rsp_free)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESP && rsp_free)
        begin
            rsp_reg.status      <= status_reg;
            rsp_reg.result_addr <= result_reg;
            rsp_reg.used_bytes  <= used_reg;
            rsp_reg.free_bytes  <= SIZE_W'(HEAP_BYTES) - used_reg;
            rsp_reg.block_count <= count_reg;
            rsp_reg.alloc_count <= allocs_reg;
            rsp_reg.free_count  <= frees_reg;
            rsp_reg.merge_count <= merges_reg;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SIZE_W'(HEAP_BYTES))
        else $error("used bytes exceed heap");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while busy");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import hba_pkg::*;

    localparam int HEAP   = 65536;
    localparam int NBLK   = 64;
    localparam int HDR    = 16;
    localparam int MINA   = 16;
    localparam int ALN    = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hba_stream_if #(.T(req_t))       req_ch ();
    hba_stream_if #(.T(logic [1:0])) cfg_ch ();
    hba_stream_if #(.T(rsp_t))       rsp_ch ();

    heap_block_allocator uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .cfg  (cfg_ch.sink),
        .rsp  (rsp_ch.source)
    );

    // Heap table mirror: offsets, payload sizes and free flags, in address order.
    class heap_scoreboard;
        int unsigned offs[NBLK];
        int unsigned sizes[NBLK];
        bit          freeb[NBLK];
        int unsigned nblocks;
        int unsigned used_b;
        int unsigned free_b;
        bit [31:0]   allocs;
        bit [31:0]   frees;
        bit [31:0]   merges;
        bit [1:0]    fit;
        rsp_t        pending[$];
        int          errors;
        int          checked;
        int unsigned live[$];

        function void clear();
            for (int i = 0; i < NBLK; i++)
            begin
                offs[i] = 0;
                sizes[i] = 0;
                freeb[i] = 1'b0;
            end
            sizes[0] = HEAP - HDR;
            freeb[0] = 1'b1;
            nblocks = 1;
            used_b = 0;
            free_b = HEAP;
            allocs = 0;
            frees = 0;
            merges = 0;
            fit = 2'd0;
            errors = 0;
            checked = 0;
            live.delete();
        endfunction

        function void move_entry(int unsigned d, int unsigned s);
            offs[d] = offs[s];
            sizes[d] = sizes[s];
            freeb[d] = freeb[s];
        endfunction

        function void coalesce();
            int unsigned i;
            i = 0;
            while (i + 1 < nblocks)
            begin
                if (freeb[i] && freeb[i+1])
                begin
                    sizes[i] += HDR + sizes[i+1];
                    for (int unsigned j = i + 1; j + 1 < nblocks; j++)
                        move_entry(j, j + 1);
                    nblocks--;
                    merges++;
                end
                else
                    i++;
            end
        endfunction

        function void allocate(int unsigned sz, output status_t st, output int unsigned ad);
            int unsigned need;
            int pick;
            st = ST_ALLOC_FAIL;
            ad = 0;
            if (sz == 0)
                return;
            need = ((sz + ALN - 1) / ALN) * ALN;
            pick = -1;
            for (int i = 0; i < nblocks; i++)
            begin
                if (!freeb[i] || sizes[i] < need)
                    continue;
                if (pick < 0)
                begin
                    pick = i;
                    if (fit != FIT_BEST && fit != FIT_WORST)
                        break;
                end
                else if (fit == FIT_BEST && sizes[i] < sizes[pick])
                    pick = i;
                else if (fit == FIT_WORST && sizes[i] > sizes[pick])
                    pick = i;
            end
            if (pick < 0)
                return;
            if (sizes[pick] > need + HDR + MINA && nblocks < NBLK)
            begin
                for (int unsigned j = nblocks; j > pick + 1; j--)
                    move_entry(j, j - 1);
                offs[pick+1] = offs[pick] + HDR + need;
                sizes[pick+1] = sizes[pick] - need - HDR;
                freeb[pick+1] = 1'b1;
                sizes[pick] = need;
                nblocks++;
            end
            freeb[pick] = 1'b0;
            used_b += sizes[pick] + HDR;
            free_b -= sizes[pick] + HDR;
            allocs++;
            st = ST_DONE;
            ad = (offs[pick] + HDR) & 16'hFFFF;
            live.push_back(ad);
        endfunction

        function status_t release_block(int unsigned ad);
            for (int i = 0; i < nblocks; i++)
            begin
                if (!freeb[i] && offs[i] + HDR == ad)
                begin
                    freeb[i] = 1'b1;
                    used_b -= sizes[i] + HDR;
                    free_b += sizes[i] + HDR;
                    frees++;
                    coalesce();
                    foreach (live[k])
                        if (live[k] == ad)
                        begin
                            live.delete(k);
                            break;
                        end
                    return ST_DONE;
                end
            end
            return ST_FREE_REJECT;
        endfunction

        // Note an accepted request: update the mirror and queue the response.
        function void note_request(req_t r);
            rsp_t e;
            status_t st;
            int unsigned ad;
            ad = 0;
            if (r.func == FUNC_ALLOC)
                allocate(32'(r.request_size), st, ad);
            else
                st = release_block(32'(r.payload_addr));
            e.status = st;
            e.result_addr = ad[15:0];
            e.used_bytes = used_b[16:0];
            e.free_bytes = free_b[16:0];
            e.block_count = nblocks[6:0];
            e.alloc_count = allocs;
            e.free_count = frees;
            e.merge_count = merges;
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %0s: got %0d expected %0d (response %0d)", what, got, want,
                     checked);
            errors++;
        endtask

        task check_response(rsp_t g);
            rsp_t e;
            if (pending.size() == 0)
            begin
                report("unexpected response", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (g.status !== e.status) report("status", g.status, e.status);
            if (g.result_addr !== e.result_addr) report("result_addr", g.result_addr, e.result_addr);
            if (g.used_bytes !== e.used_bytes) report("used_bytes", g.used_bytes, e.used_bytes);
            if (g.free_bytes !== e.free_bytes) report("free_bytes", g.free_bytes, e.free_bytes);
            if (g.block_count !== e.block_count) report("block_count", g.block_count, e.block_count);
            if (g.alloc_count !== e.alloc_count) report("alloc_count", g.alloc_count, e.alloc_count);
            if (g.free_count !== e.free_count) report("free_count", g.free_count, e.free_count);
            if (g.merge_count !== e.merge_count) report("merge_count", g.merge_count, e.merge_count);
            checked++;
        endtask
    endclass

    heap_scoreboard sb;
    int n_alloc_req;
    int n_free_req;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold a request until accepted; inputs change on the falling edge only.
    // Valid drops at the start of the next request when it idles first.
    task automatic send_request(logic fn, logic [15:0] sz, logic [15:0] ad);
        req_t r;
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        r.func = fn;
        r.request_size = sz;
        r.payload_addr = ad;
        req_ch.data <= r;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
        if (fn == FUNC_ALLOC) n_alloc_req++; else n_free_req++;
        @(negedge clk);
    endtask

    // Drain all pending responses, then let the block settle before a write.
    task automatic write_fit(logic [1:0] m);
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_ch.data <= m;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.fit = m;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Response side: random stall per response, with stall-free stretches.
    initial
    begin
        int stall;
        int calm;
        calm = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm > 0)
            begin
                calm--;
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 9);
                if ($urandom_range(0, 15) == 0) calm = 30;
            end
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            sb.check_response(rsp_ch.data);
        end
    end

    // Pick an address to free: mostly a live block, otherwise noise.
    function automatic logic [15:0] free_target();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && sb.live.size() != 0)
            return 16'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
        else if (k == 7 && sb.live.size() != 0)
            return 16'(sb.live[$urandom_range(0, sb.live.size() - 1)] + 8);
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] rand_size();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'($urandom_range(0, 65535));
        if (k == 1) return 16'd0;
        if (k < 4) return 16'($urandom_range(1000, 6000));
        return 16'($urandom_range(1, 300));
    endfunction

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sb = new();
        sb.clear();
        n_alloc_req = 0;
        n_free_req = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, zero size, unfittable, bad frees, full heap.
        send_request(FUNC_ALLOC, 16'd0, 16'hFFFF);
        send_request(FUNC_FREE, 16'hFFFF, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd16);
        send_request(FUNC_ALLOC, 16'd1, 16'd0);
        send_request(FUNC_ALLOC, 16'd100, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd24);
        send_request(FUNC_FREE, 16'd0, 16'd16);
        send_request(FUNC_FREE, 16'd0, 16'd16);
        send_request(FUNC_ALLOC, 16'hFFFF, 16'd0);
        send_request(FUNC_ALLOC, 16'd65480, 16'd0);
        send_request(FUNC_FREE, 16'd0, 16'd16);
        // Carve many small blocks to fill the table, then hand out a tail whole.
        for (int i = 0; i < 66; i++)
            send_request(FUNC_ALLOC, 16'd8, 16'd0);
        write_fit(2'd3);
        while (sb.live.size() != 0)
            send_request(FUNC_FREE, 16'd0, 16'(sb.live[0]));

        // Random phases over every fit mode; first fit and worst fit as extremes.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_fit(ph[1:0]);
            for (int i = 0; i < 52; i++)
            begin
                if ($urandom_range(0, 9) < 5 || sb.live.size() == 0)
                    send_request(FUNC_ALLOC, rand_size(), 16'($urandom_range(0, 65535)));
                else
                    send_request(FUNC_FREE, 16'($urandom_range(0, 65535)), free_target());
            end
        end

        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        $display("covered %0d allocate and %0d free requests over all fit modes",
                 n_alloc_req, n_free_req);
        $display("final table held %0d blocks, %0d merges", sb.nblocks, sb.merges);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
